### hw/rtl/assert_macros.svh
// Assertion macros shared by the blend unit RTL.
// Needs a clk and an active-low rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_AT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(label, expr, msg) \
  `ASSERT_AT(label, !(expr), msg)

`endif

### hw/rtl/tbfb_pkg.sv
// Shared types, constants and arithmetic helpers for the two-band feather blend unit.
// No dependencies.
package tbfb_pkg;

  localparam int MOSAIC_PIXELS_DEF = 65536;
  localparam int CHANNELS_DEF      = 3;
  localparam int IN_CH             = 3;
  localparam int IDX_W             = 16;
  localparam int PIX_W             = 8;
  localparam int IN_TDATA_W        = 72;
  localparam int OUT_TDATA_W       = 40;
  localparam logic [PIX_W-1:0] FULL_WEIGHT = 8'd255;

  typedef enum logic {
    CMD_BLEND = 1'b0,
    CMD_CLEAR = 1'b1
  } cmd_t;

  typedef struct packed {
    logic accept;
    logic prod_en;
    logic quot_en;
    logic wb_en;
    logic out_load;
    logic clr_step;
  } ctl_cmd_t;

  typedef struct packed {
    logic clr_last;
  } dp_sts_t;

  // floor(x / 255), exact for x <= 255*255
  function automatic logic [PIX_W-1:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
    return t[15:8];
  endfunction

  // clamp(q + hi - lo) to a byte
  function automatic logic [PIX_W-1:0] detail_clamp(input logic [PIX_W-1:0] q,
                                                    input logic [PIX_W-1:0] hi,
                                                    input logic [PIX_W-1:0] lo);
    logic signed [9:0] v;
    v = signed'({2'b00, q}) + signed'({2'b00, hi}) - signed'({2'b00, lo});
    if (v < 10'sd0) begin
      return '0;
    end else if (v > 10'sd255) begin
      return 8'd255;
    end else begin
      return v[7:0];
    end
  endfunction

endpackage

### hw/rtl/two_band_feather_blend_unit.sv
// Blend request: the read, multiply, divide-by-255, write-back and result-load steps run in
// order; the result load waits for a free result register, and in_tready stays low meanwhile.
// Clear request: one store entry per cycle, then a result load as for a blend request.
// Reset (rst_n low, synchronous): control cleared, then a clearing pass over every entry of the
// low-band and coverage store with in_tready low.
// Top level of the two-band feather blend unit; depends on tbfb_pkg, tbfb_ctrl, tbfb_datapath.
module two_band_feather_blend_unit #(
  parameter int MOSAIC_PIXELS = tbfb_pkg::MOSAIC_PIXELS_DEF,
  parameter int CHANNELS      = tbfb_pkg::CHANNELS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // pixel_index, weight, lo_chan0, lo_chan1, lo_chan2, hi_chan0, hi_chan1, hi_chan2
  input  logic [tbfb_pkg::IN_TDATA_W-1:0]     in_tdata,
  // cmd
  input  logic                                in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // out_index, out_chan0, out_chan1, out_chan2
  output logic [tbfb_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // written
  output logic                                out_tuser
);

  localparam int PW = tbfb_pkg::PIX_W;
  localparam int IW = tbfb_pkg::IDX_W;

  tbfb_pkg::ctl_cmd_t ctl_cmd;
  tbfb_pkg::dp_sts_t  dp_sts;
  tbfb_pkg::cmd_t     req_cmd;
  logic [PW-1:0]      in_lo [tbfb_pkg::IN_CH];
  logic [PW-1:0]      in_hi [tbfb_pkg::IN_CH];
  logic [PW-1:0]      res_chan [tbfb_pkg::IN_CH];
  logic [IW-1:0]      res_index;

  assign req_cmd = tbfb_pkg::cmd_t'(in_tuser);

  for (genvar c = 0; c < tbfb_pkg::IN_CH; c++) begin : g_unpack
    assign in_lo[c] = in_tdata[IW + PW + c*PW +: PW];
    assign in_hi[c] = in_tdata[IW + PW + tbfb_pkg::IN_CH*PW + c*PW +: PW];
  end

  tbfb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_cmd     (req_cmd),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (ctl_cmd),
    .sts        (dp_sts)
  );

  tbfb_datapath #(
    .MOSAIC_PIXELS (MOSAIC_PIXELS),
    .CHANNELS      (CHANNELS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (ctl_cmd),
    .sts         (dp_sts),
    .in_cmd      (req_cmd),
    .in_index    (in_tdata[IW-1:0]),
    .in_weight   (in_tdata[IW +: PW]),
    .in_lo       (in_lo),
    .in_hi       (in_hi),
    .out_index   (res_index),
    .out_written (out_tuser),
    .out_chan    (res_chan)
  );

  assign out_tdata = {res_chan[2], res_chan[1], res_chan[0], res_index};

endmodule

### hw/rtl/tbfb_datapath.sv
// Datapath: item registers, low-band/coverage memory, feather arithmetic, result register.
// Depends on tbfb_pkg and assert_macros.svh; driven by tbfb_ctrl.
`include "assert_macros.svh"

module tbfb_datapath #(
  parameter int MOSAIC_PIXELS = tbfb_pkg::MOSAIC_PIXELS_DEF,
  parameter int CHANNELS      = tbfb_pkg::CHANNELS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  tbfb_pkg::ctl_cmd_t          cmd,
  output tbfb_pkg::dp_sts_t           sts,
  input  tbfb_pkg::cmd_t              in_cmd,
  input  logic [tbfb_pkg::IDX_W-1:0]  in_index,
  input  logic [tbfb_pkg::PIX_W-1:0]  in_weight,
  input  logic [tbfb_pkg::PIX_W-1:0]  in_lo [tbfb_pkg::IN_CH],
  input  logic [tbfb_pkg::PIX_W-1:0]  in_hi [tbfb_pkg::IN_CH],
  output logic [tbfb_pkg::IDX_W-1:0]  out_index,
  output logic                        out_written,
  output logic [tbfb_pkg::PIX_W-1:0]  out_chan [tbfb_pkg::IN_CH]
);

  localparam int ADDR_W   = $clog2(MOSAIC_PIXELS);
  localparam int STORE_CH = (CHANNELS < tbfb_pkg::IN_CH) ? CHANNELS : tbfb_pkg::IN_CH;
  localparam int PW       = tbfb_pkg::PIX_W;
  localparam int MEM_W    = PW * STORE_CH + 1;

  logic [MEM_W-1:0]  mem [MOSAIC_PIXELS];
  logic [MEM_W-1:0]  rd_data_r;
  logic [MEM_W-1:0]  wb_data;
  logic [ADDR_W-1:0] clr_addr_r;
  logic [ADDR_W-1:0] addr_r;
  logic [tbfb_pkg::IDX_W-1:0] idx_r;
  logic [PW-1:0]     w_r;
  logic [PW-1:0]     lo_r [tbfb_pkg::IN_CH];
  logic [PW-1:0]     hi_r [tbfb_pkg::IN_CH];
  logic              wr_r;
  logic              cov;
  logic [PW-1:0]     res_lane [tbfb_pkg::IN_CH];
  logic [tbfb_pkg::IDX_W-1:0] out_idx_r;
  logic              out_wr_r;
  logic [PW-1:0]     out_ch_r [tbfb_pkg::IN_CH];

  assign cov          = rd_data_r[MEM_W-1];
  assign sts.clr_last = (clr_addr_r == ADDR_W'(MOSAIC_PIXELS - 1));

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      idx_r     <= in_index;
      addr_r    <= ADDR_W'(in_index);
      w_r       <= in_weight;
      lo_r      <= in_lo;
      hi_r      <= in_hi;
      wr_r      <= (in_cmd == tbfb_pkg::CMD_BLEND) && (in_weight != '0) &&
                   (32'(in_index) < 32'(MOSAIC_PIXELS));
      rd_data_r <= mem[ADDR_W'(in_index)];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      mem[clr_addr_r] <= '0;
    end else if (cmd.wb_en && wr_r) begin
      mem[addr_r] <= wb_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_step) begin
      clr_addr_r <= sts.clr_last ? '0 : clr_addr_r + ADDR_W'(1);
    end
  end

  assign wb_data[MEM_W-1] = 1'b1;

  for (genvar c = 0; c < tbfb_pkg::IN_CH; c++) begin : g_lane
    if (c < STORE_CH) begin : g_stored
      logic [15:0] pa_r;
      logic [15:0] pb_r;
      logic [PW-1:0] q_r;
      logic [PW-1:0] res_r;

      always_ff @(posedge clk) begin
        if (cmd.prod_en) begin
          pa_r <= 16'(w_r) * 16'(lo_r[c]);
          pb_r <= 16'(tbfb_pkg::FULL_WEIGHT - w_r) * 16'(rd_data_r[c*PW +: PW]);
        end
        if (cmd.quot_en) begin
          q_r <= tbfb_pkg::div255(pa_r + pb_r);
        end
        if (cmd.wb_en) begin
          res_r <= cov ? tbfb_pkg::detail_clamp(q_r, hi_r[c], lo_r[c]) : hi_r[c];
        end
      end

      assign wb_data[c*PW +: PW] = cov ? q_r : lo_r[c];
      assign res_lane[c]         = res_r;
    end else begin : g_unused
      assign res_lane[c] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_idx_r <= idx_r;
      out_wr_r  <= wr_r;
      for (int c = 0; c < tbfb_pkg::IN_CH; c++) begin
        out_ch_r[c] <= wr_r ? res_lane[c] : '0;
      end
    end
  end

  assign out_index   = out_idx_r;
  assign out_written = out_wr_r;
  assign out_chan    = out_ch_r;

  `ASSERT_NEVER(a_clr_addr_range, clr_addr_r > ADDR_W'(MOSAIC_PIXELS - 1),
                "clear sweep address beyond mosaic")

endmodule

### hw/rtl/tbfb_ctrl.sv
// Controller: sequences one request at a time, the clear sweep and the result register.
// Depends on tbfb_pkg and assert_macros.svh; drives tbfb_datapath.
`include "assert_macros.svh"

module tbfb_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  tbfb_pkg::cmd_t     in_cmd,
  output logic               out_tvalid,
  input  logic               out_tready,
  output tbfb_pkg::ctl_cmd_t cmd,
  input  tbfb_pkg::dp_sts_t  sts
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROD,
    S_QUOT,
    S_WB,
    S_DONE,
    S_CLEAR
  } state_t;

  state_t state_r, state_nxt;
  logic   out_tvalid_r, out_tvalid_nxt;
  logic   emit_r, emit_nxt;
  logic   slot_free;

  assign slot_free  = !out_tvalid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    emit_nxt  = emit_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          if (in_cmd == tbfb_pkg::CMD_CLEAR) begin
            state_nxt = S_CLEAR;
            emit_nxt  = 1'b1;
          end else begin
            state_nxt = S_PROD;
          end
        end
      end
      S_PROD: begin
        cmd.prod_en = 1'b1;
        state_nxt   = S_QUOT;
      end
      S_QUOT: begin
        cmd.quot_en = 1'b1;
        state_nxt   = S_WB;
      end
      S_WB: begin
        cmd.wb_en = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = emit_r ? S_DONE : S_IDLE;
          emit_nxt  = 1'b0;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (cmd.out_load) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      out_tvalid_r <= 1'b0;
      emit_r       <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      emit_r       <= emit_nxt;
    end
  end

  `ASSERT_AT(a_load_slot_free, cmd.out_load |-> (!out_tvalid_r || out_tready),
             "result register overwritten before it was taken")
  `ASSERT_AT(a_accept_next, (in_tvalid && in_tready) |=> (state_r == S_PROD || state_r == S_CLEAR),
             "accepted request not started")
  `ASSERT_AT(a_sweep_whole, (state_r == S_CLEAR && !sts.clr_last) |=> (state_r == S_CLEAR),
             "clear sweep left early")

endmodule
